>>> rtl/kwl_pkg.sv
// Package for the keyword lexer: token kinds, scan modes, character classes
// and the result record passed from the front to the back end.
// No dependencies.
`default_nettype none
package kwl_pkg;

	typedef enum logic [2:0] {
		M_IDLE    = 3'd0,
		M_INT     = 3'd1,
		M_FRAC    = 3'd2,
		M_WORD    = 3'd3,
		M_OPER    = 3'd4,
		M_STRING  = 3'd5,
		M_COMMENT = 3'd6,
		M_DROP    = 3'd7
	} mode_t;

	localparam logic [5:0] K_NUMBER = 6'd0;
	localparam logic [5:0] K_IF     = 6'd1;
	localparam logic [5:0] K_THEN   = 6'd2;
	localparam logic [5:0] K_ENDIF  = 6'd3;
	localparam logic [5:0] K_ELSE   = 6'd4;
	localparam logic [5:0] K_FOR    = 6'd5;
	localparam logic [5:0] K_IN     = 6'd6;
	localparam logic [5:0] K_ENDFOR = 6'd7;
	localparam logic [5:0] K_BOOL   = 6'd8;
	localparam logic [5:0] K_BEGIN  = 6'd9;
	localparam logic [5:0] K_END    = 6'd10;
	localparam logic [5:0] K_DEFINE = 6'd11;
	localparam logic [5:0] K_IDENT  = 6'd12;
	localparam logic [5:0] K_PLUS   = 6'd13;
	localparam logic [5:0] K_MINUS  = 6'd14;
	localparam logic [5:0] K_STAR   = 6'd15;
	localparam logic [5:0] K_SLASH  = 6'd16;
	localparam logic [5:0] K_MOD    = 6'd17;
	localparam logic [5:0] K_HAT    = 6'd18;
	localparam logic [5:0] K_INC    = 6'd19;
	localparam logic [5:0] K_DEC    = 6'd20;
	localparam logic [5:0] K_EQ     = 6'd21;
	localparam logic [5:0] K_LESS   = 6'd22;
	localparam logic [5:0] K_GREATER= 6'd23;
	localparam logic [5:0] K_LEQ    = 6'd24;
	localparam logic [5:0] K_GREQ   = 6'd25;
	localparam logic [5:0] K_NEQ    = 6'd26;
	localparam logic [5:0] K_AND    = 6'd27;
	localparam logic [5:0] K_OR     = 6'd28;
	localparam logic [5:0] K_NOT    = 6'd29;
	localparam logic [5:0] K_ASSIGN = 6'd30;
	localparam logic [5:0] K_LPAREN = 6'd31;
	localparam logic [5:0] K_RPAREN = 6'd32;
	localparam logic [5:0] K_COMMA  = 6'd33;
	localparam logic [5:0] K_STRING = 6'd34;
	localparam logic [5:0] K_COND   = 6'd35;
	localparam logic [5:0] K_COLON  = 6'd36;

	localparam logic [1:0] E_NONE     = 2'd0;
	localparam logic [1:0] E_BAD_OPER = 2'd1;
	localparam logic [1:0] E_UNEXP    = 2'd2;
	localparam logic [1:0] E_BAD_NUM  = 2'd3;

	// One result, as packed on the output tdata (highest field first)
	typedef struct packed {
		logic [1:0]  error_code;
		logic [15:0] start_position;
		logic [7:0]  text_length;
		logic        has_token;
		logic [5:0]  token_kind;
	} result_t;

	// Front-end output for one character: up to two results
	typedef struct packed {
		logic    two;
		result_t r1;
		result_t r0;
	} group_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return c == "+" || c == "-" || c == "*" || c == "/" || c == "^" ||
			c == "%" || c == "=" || c == ">" || c == "<" || c == "!" ||
			c == "|" || c == "&";
	endfunction

	// Operator lookup on the first two characters; kind 0 means no match
	function automatic logic [5:0] oper_kind(input logic [15:0] s);
		logic [5:0] k;
		k = K_NUMBER;
		case (s)
			16'h002b: k = K_PLUS;
			16'h002d: k = K_MINUS;
			16'h002a: k = K_STAR;
			16'h002f: k = K_SLASH;
			16'h0025: k = K_MOD;
			16'h005e: k = K_HAT;
			16'h2b2b: k = K_INC;
			16'h2d2d: k = K_DEC;
			16'h3d3d: k = K_EQ;
			16'h003c: k = K_LESS;
			16'h003e: k = K_GREATER;
			16'h3c3d: k = K_LEQ;
			16'h3e3d: k = K_GREQ;
			16'h213d: k = K_NEQ;
			16'h2626: k = K_AND;
			16'h7c7c: k = K_OR;
			16'h0021: k = K_NOT;
			16'h003d: k = K_ASSIGN;
			default:  k = K_NUMBER;
		endcase
		return k;
	endfunction

	// Keyword lookup on a 64-bit right-aligned word buffer
	function automatic logic [5:0] word_kind(input logic [63:0] w);
		logic [5:0] k;
		k = K_IDENT;
		case (w)
			64'h4946:         k = K_IF;
			64'h5448454e:     k = K_THEN;
			64'h454e444946:   k = K_ENDIF;
			64'h454c5345:     k = K_ELSE;
			64'h464f52:       k = K_FOR;
			64'h494e:         k = K_IN;
			64'h454e44464f52: k = K_ENDFOR;
			64'h74727565:     k = K_BOOL;
			64'h66616c7365:   k = K_BOOL;
			64'h424547494e:   k = K_BEGIN;
			64'h454e44:       k = K_END;
			64'h444546494e45: k = K_DEFINE;
			default:          k = K_IDENT;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

>>> rtl/keyword_lexer_unit.sv
// Top level of the keyword lexer: character stream in, token stream out.
// Instantiates kwl_front and kwl_back; uses kwl_pkg.
//
//  channel | dir | tdata (low bit first)                      | tlast
//  s_axis  | in  | char_code[7:0]                             | end_of_input
//  m_axis  | out | kind[5:0] has len[7:0] start[15:0] err[1:0] | last result
//
// One character beat is taken per cycle while the queue has space; results are
// registered in the result queue before they reach m_axis. A character causing
// two results uses two output beats, set by the single output port of the four-entry result queue.
// Input is held off only while that queue is full. Reset clears the scan
// state and empties the queue.
`default_nettype none
module keyword_lexer_unit #(
	parameter int POSITION_BITS = 16,
	parameter int KEYWORD_CHARS = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // char_code[7:0]
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // kind, has_token, length, start, error
	output logic             m_axis_tlast
);

	kwl_pkg::group_t  grp;
	kwl_pkg::result_t res;
	logic             grp_any, in_fire, space;

	assign s_axis_tready = space;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	kwl_front #(.POSITION_BITS(POSITION_BITS), .KEYWORD_CHARS(KEYWORD_CHARS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.c(s_axis_tdata), .eoi(s_axis_tlast),
		.grp(grp), .grp_any(grp_any)
	);

	kwl_back u_back (
		.clk(clk), .arst_n(arst_n),
		.push(in_fire && grp_any), .push_grp(grp), .space(space),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_res(res), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {7'd0, res};

endmodule
`default_nettype wire

>>> rtl/kwl_front.sv
// Front end of the keyword lexer: takes one character beat per cycle on in_fire,
// keeps the scan state and forms the results, up to two, it causes. Uses kwl_pkg.
`default_nettype none
module kwl_front #(
	parameter int POSITION_BITS = 16,
	parameter int KEYWORD_CHARS = 6
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_fire,
	input  wire logic [7:0]       c,
	input  wire logic             eoi,
	output kwl_pkg::group_t       grp,
	output logic                  grp_any
);

	localparam int WB = 8 * KEYWORD_CHARS;

	kwl_pkg::mode_t          mode_q, mode_d;
	logic [WB-1:0]           word_q, word_d;
	logic                    wlong_q, wlong_d;
	logic [15:0]             opc_q, opc_d;
	logic                    olong_q, olong_d;
	logic [7:0]              len_q, len_d;
	logic [POSITION_BITS-1:0] start_q, start_d;
	logic [POSITION_BITS-1:0] pos_q;

	kwl_pkg::result_t        pend, tok, r0;
	logic                    have_pend, have_tok;
	logic                    oper_ok, num_legal;
	logic [7:0]              len_inc;
	logic [63:0]             word_ext;
	logic [5:0]              okind;

	always_comb begin
		word_ext = 64'(word_q);
		okind    = kwl_pkg::oper_kind(opc_q);
		oper_ok  = !olong_q && okind != kwl_pkg::K_NUMBER;
		len_inc  = (len_q == 8'd255) ? len_q : len_q + 8'd1;
		num_legal = kwl_pkg::is_space(c) || c == ")" || c == "," || c == ";" ||
			kwl_pkg::is_op(c);
	end

	// Pending-token result for the current mode
	always_comb begin
		pend = '0;
		pend.has_token      = 1'b1;
		pend.text_length    = len_q;
		pend.start_position = 16'(start_q);
		case (mode_q)
			kwl_pkg::M_INT, kwl_pkg::M_FRAC: pend.token_kind = kwl_pkg::K_NUMBER;
			kwl_pkg::M_WORD:   pend.token_kind = wlong_q ? kwl_pkg::K_IDENT
				: kwl_pkg::word_kind(word_ext);
			kwl_pkg::M_STRING: pend.token_kind = kwl_pkg::K_STRING;
			kwl_pkg::M_OPER: begin
				if (oper_ok) begin
					pend.token_kind = okind;
				end else begin
					pend.has_token  = 1'b0;
					pend.error_code = kwl_pkg::E_BAD_OPER;
				end
			end
			default: pend.token_kind = kwl_pkg::K_NUMBER;
		endcase
	end

	// Scan step: next state and results
	always_comb begin
		logic start_new;
		start_new = 1'b0;
		mode_d  = mode_q;
		word_d  = word_q;
		wlong_d = wlong_q;
		opc_d   = opc_q;
		olong_d = olong_q;
		len_d   = len_q;
		start_d = start_q;
		have_pend = 1'b0;
		have_tok  = 1'b0;
		tok = '0;
		r0 = '0;
		grp = '0;
		grp_any = 1'b0;

		if (eoi) begin
			have_pend = mode_q inside {kwl_pkg::M_INT, kwl_pkg::M_FRAC,
				kwl_pkg::M_WORD, kwl_pkg::M_OPER, kwl_pkg::M_STRING};
			have_tok = 1'b1;
			tok.token_kind = kwl_pkg::K_END;
			tok.has_token  = 1'b1;
			tok.start_position = 16'(pos_q);
			mode_d = kwl_pkg::M_IDLE;
		end else begin
			case (mode_q)
				kwl_pkg::M_DROP: mode_d = kwl_pkg::M_IDLE;
				kwl_pkg::M_COMMENT: if (c == 8'h0a) mode_d = kwl_pkg::M_IDLE;
				kwl_pkg::M_STRING: begin
					if (c == "\"") begin
						have_pend = 1'b1;
						mode_d = kwl_pkg::M_IDLE;
					end else begin
						len_d = len_inc;
					end
				end
				kwl_pkg::M_INT, kwl_pkg::M_FRAC: begin
					if (kwl_pkg::is_digit(c)) begin
						len_d = len_inc;
					end else if (c == "." && mode_q == kwl_pkg::M_INT) begin
						mode_d = kwl_pkg::M_FRAC;
						len_d = len_inc;
					end else begin
						have_pend = 1'b1;
						mode_d = kwl_pkg::M_IDLE;
						start_new = num_legal;
					end
				end
				kwl_pkg::M_WORD: begin
					if (kwl_pkg::is_alpha(c) || kwl_pkg::is_digit(c)) begin
						if (len_q < 8'(KEYWORD_CHARS))
							word_d = {word_q[WB-9:0], c};
						else
							wlong_d = 1'b1;
						len_d = len_inc;
					end else begin
						have_pend = 1'b1;
						start_new = 1'b1;
					end
				end
				kwl_pkg::M_OPER: begin
					if (kwl_pkg::is_op(c)) begin
						if (len_q < 8'd2)
							opc_d = {opc_q[7:0], c};
						else
							olong_d = 1'b1;
						len_d = len_inc;
					end else begin
						have_pend = 1'b1;
						mode_d = kwl_pkg::M_IDLE;
						start_new = oper_ok;
					end
				end
				default: start_new = 1'b1;
			endcase

			// Start of a new token from this character
			if (start_new) begin
				mode_d = kwl_pkg::M_IDLE;
				tok.has_token = 1'b1;
				tok.text_length = 8'd1;
				tok.start_position = 16'(pos_q);
				if (kwl_pkg::is_space(c)) begin
				end else if (c == "#") begin
					mode_d = kwl_pkg::M_COMMENT;
				end else if (kwl_pkg::is_digit(c)) begin
					mode_d = kwl_pkg::M_INT;
					len_d = 8'd1;
					start_d = pos_q;
				end else if (kwl_pkg::is_alpha(c)) begin
					mode_d = kwl_pkg::M_WORD;
					len_d = 8'd1;
					start_d = pos_q;
					word_d = WB'(c);
					wlong_d = 1'b0;
				end else if (kwl_pkg::is_op(c)) begin
					mode_d = kwl_pkg::M_OPER;
					len_d = 8'd1;
					start_d = pos_q;
					opc_d = {8'd0, c};
					olong_d = 1'b0;
				end else if (c == "\"") begin
					mode_d = kwl_pkg::M_STRING;
					len_d = 8'd0;
					start_d = pos_q + POSITION_BITS'(1);
				end else begin
					have_tok = 1'b1;
					case (c)
						"(": tok.token_kind = kwl_pkg::K_LPAREN;
						")": tok.token_kind = kwl_pkg::K_RPAREN;
						",": tok.token_kind = kwl_pkg::K_COMMA;
						"?": tok.token_kind = kwl_pkg::K_COND;
						":": tok.token_kind = kwl_pkg::K_COLON;
						";": tok.token_kind = kwl_pkg::K_END;
						default: begin
							tok.has_token = 1'b0;
							tok.error_code = kwl_pkg::E_UNEXP;
							mode_d = kwl_pkg::M_DROP;
						end
					endcase
				end
			end
		end

		r0 = pend;
		if (!eoi && (mode_q == kwl_pkg::M_INT || mode_q == kwl_pkg::M_FRAC) &&
			!num_legal)
			r0.error_code = kwl_pkg::E_BAD_NUM;
		if (have_pend) begin
			grp.r0 = r0;
			grp.r1 = tok;
			grp.two = have_tok;
		end else begin
			grp.r0 = tok;
		end
		grp_any = have_pend || have_tok;
	end

	// Hold scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= kwl_pkg::M_IDLE;
			word_q  <= '0;
			wlong_q <= 1'b0;
			opc_q   <= '0;
			olong_q <= 1'b0;
			len_q   <= '0;
			start_q <= '0;
			pos_q   <= '0;
		end else if (in_fire) begin
			mode_q  <= mode_d;
			word_q  <= word_d;
			wlong_q <= wlong_d;
			opc_q   <= opc_d;
			olong_q <= olong_d;
			len_q   <= len_d;
			start_q <= start_d;
			if (!eoi)
				pos_q <= pos_q + POSITION_BITS'(1);
		end
	end

endmodule
`default_nettype wire

>>> rtl/kwl_back.sv
// Back end of the keyword lexer: a short queue of result groups and the
// output stage that sends one result beat at a time. Uses kwl_pkg.
`default_nettype none
module kwl_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire kwl_pkg::group_t push_grp,
	output logic             space,
	output logic             out_valid,
	input  wire logic        out_ready,
	output kwl_pkg::result_t out_res,
	output logic             out_last
);

	localparam int DEPTH = 4;

	kwl_pkg::group_t mem_q [DEPTH];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       half_q;
	logic       pop, beat;
	kwl_pkg::group_t head;

	assign head      = mem_q[rd_q];
	assign out_valid = cnt_q != 3'd0;
	assign out_res   = half_q ? head.r1 : head.r0;
	assign out_last  = half_q || !head.two;
	assign beat      = out_valid && out_ready;
	assign pop       = beat && out_last;
	assign space     = cnt_q != 3'(DEPTH);

	// Store groups
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_grp;
	end

	// Advance pointers and the half selector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			cnt_q  <= '0;
			half_q <= 1'b0;
		end else begin
			if (push)
				wr_q <= wr_q + 2'd1;
			if (pop)
				rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
			if (pop)
				half_q <= 1'b0;
			else if (beat)
				half_q <= 1'b1;
		end
	end

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking bench for keyword_lexer_unit: streams characters in, predicts
// each token result with its own scanner, and compares every output beat.
// Depends on kwl_pkg and the keyword_lexer_unit RTL.
`default_nettype none
module tb_top;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_QUIET = 200;

	typedef struct {
		logic [7:0] ch;
		logic       eoi;
		bit         drain_first;
	} char_beat_t;

	typedef struct {
		kwl_pkg::result_t tok;
		logic             last;
	} token_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	char_beat_t  src_q[$];
	token_beat_t tok_q[$];
	int          errors;
	int          chars_total;
	int          chars_sent;
	int          quiet_cycles;
	int          tx_gap;
	int          rx_gap;
	int          rx_hold;
	bit          rx_hold_done;
	char_beat_t  cur_beat;

	// Scanner state of the predictor
	kwl_pkg::mode_t sc_mode;
	logic [63:0] sc_word;
	bit          sc_word_long;
	logic [15:0] sc_oper;
	bit          sc_oper_long;
	logic [7:0]  sc_len;
	logic [15:0] sc_start;
	logic [15:0] sc_pos;

	keyword_lexer_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit ch_white(logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit ch_num(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit ch_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit ch_opchar(logic [7:0] c);
		case (c)
			"+", "-", "*", "/", "^", "%", "=", ">", "<", "!", "|", "&": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [5:0] keyword_of(logic [63:0] w);
		case (w)
			64'("IF"):     return kwl_pkg::K_IF;
			64'("THEN"):   return kwl_pkg::K_THEN;
			64'("ENDIF"):  return kwl_pkg::K_ENDIF;
			64'("ELSE"):   return kwl_pkg::K_ELSE;
			64'("FOR"):    return kwl_pkg::K_FOR;
			64'("IN"):     return kwl_pkg::K_IN;
			64'("ENDFOR"): return kwl_pkg::K_ENDFOR;
			64'("true"):   return kwl_pkg::K_BOOL;
			64'("false"):  return kwl_pkg::K_BOOL;
			64'("BEGIN"):  return kwl_pkg::K_BEGIN;
			64'("END"):    return kwl_pkg::K_END;
			64'("DEFINE"): return kwl_pkg::K_DEFINE;
			default:       return kwl_pkg::K_IDENT;
		endcase
	endfunction

	// Operator kind of a two-character window; NUMBER means not an operator
	function automatic logic [5:0] operator_of(logic [15:0] s);
		case (s)
			16'("+"):  return kwl_pkg::K_PLUS;
			16'("-"):  return kwl_pkg::K_MINUS;
			16'("*"):  return kwl_pkg::K_STAR;
			16'("/"):  return kwl_pkg::K_SLASH;
			16'("%"):  return kwl_pkg::K_MOD;
			16'("^"):  return kwl_pkg::K_HAT;
			16'("++"): return kwl_pkg::K_INC;
			16'("--"): return kwl_pkg::K_DEC;
			16'("=="): return kwl_pkg::K_EQ;
			16'("<"):  return kwl_pkg::K_LESS;
			16'(">"):  return kwl_pkg::K_GREATER;
			16'("<="): return kwl_pkg::K_LEQ;
			16'(">="): return kwl_pkg::K_GREQ;
			16'("!="): return kwl_pkg::K_NEQ;
			16'("&&"): return kwl_pkg::K_AND;
			16'("||"): return kwl_pkg::K_OR;
			16'("!"):  return kwl_pkg::K_NOT;
			16'("="):  return kwl_pkg::K_ASSIGN;
			default:   return kwl_pkg::K_NUMBER;
		endcase
	endfunction

	function automatic void push_token(logic [5:0] k, logic h, logic [7:0] len,
			logic [15:0] st, logic [1:0] e);
		token_beat_t t;
		t.tok.token_kind = k;
		t.tok.has_token = h;
		t.tok.text_length = len;
		t.tok.start_position = st;
		t.tok.error_code = e;
		t.last = 1'b0;
		tok_q.push_back(t);
	endfunction

	function automatic void push_word();
		push_token(sc_word_long ? kwl_pkg::K_IDENT : keyword_of(sc_word), 1'b1, sc_len,
			sc_start, kwl_pkg::E_NONE);
	endfunction

	function automatic bit push_oper();
		logic [5:0] k;
		k = sc_oper_long ? kwl_pkg::K_NUMBER : operator_of(sc_oper);
		if (k == kwl_pkg::K_NUMBER) begin
			push_token(kwl_pkg::K_NUMBER, 1'b0, sc_len, sc_start, kwl_pkg::E_BAD_OPER);
			return 1'b0;
		end
		push_token(k, 1'b1, sc_len, sc_start, kwl_pkg::E_NONE);
		return 1'b1;
	endfunction

	function automatic void lengthen();
		if (sc_len != 8'd255)
			sc_len++;
	endfunction

	function automatic void open_token(kwl_pkg::mode_t m, logic [15:0] p);
		sc_mode = m;
		sc_len = 8'd1;
		sc_start = p;
	endfunction

	// Classify a character seen with no token open
	function automatic void scan_fresh(logic [7:0] c, logic [15:0] p);
		sc_mode = kwl_pkg::M_IDLE;
		if (ch_white(c))
			return;
		if (c == "#") begin
			sc_mode = kwl_pkg::M_COMMENT;
		end else if (ch_num(c)) begin
			open_token(kwl_pkg::M_INT, p);
		end else if (ch_letter(c)) begin
			open_token(kwl_pkg::M_WORD, p);
			sc_word = 64'(c);
			sc_word_long = 1'b0;
		end else if (ch_opchar(c)) begin
			open_token(kwl_pkg::M_OPER, p);
			sc_oper = 16'(c);
			sc_oper_long = 1'b0;
		end else begin
			case (c)
				"(": push_token(kwl_pkg::K_LPAREN, 1'b1, 8'd1, p, kwl_pkg::E_NONE);
				")": push_token(kwl_pkg::K_RPAREN, 1'b1, 8'd1, p, kwl_pkg::E_NONE);
				",": push_token(kwl_pkg::K_COMMA, 1'b1, 8'd1, p, kwl_pkg::E_NONE);
				"?": push_token(kwl_pkg::K_COND, 1'b1, 8'd1, p, kwl_pkg::E_NONE);
				":": push_token(kwl_pkg::K_COLON, 1'b1, 8'd1, p, kwl_pkg::E_NONE);
				";": push_token(kwl_pkg::K_END, 1'b1, 8'd1, p, kwl_pkg::E_NONE);
				"\"": begin
					sc_mode = kwl_pkg::M_STRING;
					sc_len = 8'd0;
					sc_start = p + 16'd1;
				end
				default: begin
					push_token(kwl_pkg::K_NUMBER, 1'b0, 8'd1, p, kwl_pkg::E_UNEXP);
					sc_mode = kwl_pkg::M_DROP;
				end
			endcase
		end
	endfunction

	// Advance the scanner by one accepted character beat
	function automatic void scan_char(char_beat_t b);
		int n_prior;
		logic [15:0] p;
		bit ok;
		n_prior = tok_q.size();
		p = sc_pos;
		if (b.eoi) begin
			case (sc_mode)
				kwl_pkg::M_INT, kwl_pkg::M_FRAC:
					push_token(kwl_pkg::K_NUMBER, 1'b1, sc_len, sc_start, kwl_pkg::E_NONE);
				kwl_pkg::M_WORD: push_word();
				kwl_pkg::M_OPER: ok = push_oper();
				kwl_pkg::M_STRING:
					push_token(kwl_pkg::K_STRING, 1'b1, sc_len, sc_start, kwl_pkg::E_NONE);
				default: ;
			endcase
			push_token(kwl_pkg::K_END, 1'b1, 8'd0, p, kwl_pkg::E_NONE);
			sc_mode = kwl_pkg::M_IDLE;
		end else begin
			sc_pos = p + 16'd1;
			case (sc_mode)
				kwl_pkg::M_DROP: sc_mode = kwl_pkg::M_IDLE;
				kwl_pkg::M_COMMENT: if (b.ch == 8'd10) sc_mode = kwl_pkg::M_IDLE;
				kwl_pkg::M_STRING: begin
					if (b.ch == "\"") begin
						push_token(kwl_pkg::K_STRING, 1'b1, sc_len, sc_start,
							kwl_pkg::E_NONE);
						sc_mode = kwl_pkg::M_IDLE;
					end else begin
						lengthen();
					end
				end
				kwl_pkg::M_INT, kwl_pkg::M_FRAC: begin
					if (ch_num(b.ch)) begin
						lengthen();
					end else if (b.ch == "." && sc_mode == kwl_pkg::M_INT) begin
						sc_mode = kwl_pkg::M_FRAC;
						lengthen();
					end else begin
						ok = ch_white(b.ch) || b.ch == ")" || b.ch == "," || b.ch == ";" ||
							ch_opchar(b.ch);
						push_token(kwl_pkg::K_NUMBER, 1'b1, sc_len, sc_start,
							ok ? kwl_pkg::E_NONE : kwl_pkg::E_BAD_NUM);
						sc_mode = kwl_pkg::M_IDLE;
						if (ok)
							scan_fresh(b.ch, p);
					end
				end
				kwl_pkg::M_WORD: begin
					if (ch_letter(b.ch) || ch_num(b.ch)) begin
						if (sc_len < 8'd6)
							sc_word = {sc_word[55:0], b.ch};
						else
							sc_word_long = 1'b1;
						lengthen();
					end else begin
						push_word();
						scan_fresh(b.ch, p);
					end
				end
				kwl_pkg::M_OPER: begin
					if (ch_opchar(b.ch)) begin
						if (sc_len < 8'd2)
							sc_oper = {sc_oper[7:0], b.ch};
						else
							sc_oper_long = 1'b1;
						lengthen();
					end else if (push_oper()) begin
						scan_fresh(b.ch, p);
					end else begin
						sc_mode = kwl_pkg::M_IDLE;
					end
				end
				default: scan_fresh(b.ch, p);
			endcase
		end
		if (tok_q.size() > n_prior)
			tok_q[tok_q.size() - 1].last = 1'b1;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
		errors++;
	endtask

	// Stimulus builders
	task automatic add_char(logic [7:0] c);
		char_beat_t b;
		b.ch = c;
		b.eoi = 1'b0;
		b.drain_first = 1'b0;
		src_q.push_back(b);
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i]);
	endtask

	task automatic add_eoi(bit drain);
		char_beat_t b;
		b.ch = 8'($urandom);
		b.eoi = 1'b1;
		b.drain_first = drain;
		src_q.push_back(b);
	endtask

	function automatic logic [7:0] rand_letter();
		return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) :
			8'($urandom_range("A", "Z"));
	endfunction

	task automatic add_random_token();
		string kw[12] = '{"IF", "THEN", "ENDIF", "ELSE", "FOR", "IN", "ENDFOR", "BEGIN",
			"END", "DEFINE", "true", "false"};
		string ops[18] = '{"+", "-", "*", "/", "%", "^", "++", "--", "==", "<", ">", "<=",
			">=", "!=", "&&", "||", "!", "="};
		string opset;
		string punct;
		int n;
		opset = "+-*/^%=><!|&";
		punct = "(),?:;";
		case ($urandom_range(0, 15))
			0, 1: add_text(kw[$urandom_range(0, 11)]);
			2: begin
				n = $urandom_range(1, 10);
				add_char(rand_letter());
				for (int i = 1; i < n; i++)
					add_char($urandom_range(0, 3) == 0 ? 8'($urandom_range("0", "9")) :
						rand_letter());
			end
			3, 4: begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					add_char(8'($urandom_range("0", "9")));
				if ($urandom_range(0, 1)) begin
					add_char(".");
					for (int i = $urandom_range(0, 3); i > 0; i--)
						add_char(8'($urandom_range("0", "9")));
				end
			end
			5, 6: add_text(ops[$urandom_range(0, 17)]);
			7: begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					add_char(opset[$urandom_range(0, 11)]);
			end
			8, 9: add_char(punct[$urandom_range(0, 5)]);
			10: begin
				add_char("\"");
				for (int i = $urandom_range(0, 6); i > 0; i--)
					add_char(8'($urandom_range(32, 126)) == "\"" ? 8'("x") :
						8'($urandom_range(32, 126)));
				if ($urandom_range(0, 7) != 0)
					add_char("\"");
			end
			11: begin
				add_char("#");
				for (int i = $urandom_range(0, 5); i > 0; i--)
					add_char(8'($urandom_range(32, 126)));
				add_char(8'd10);
			end
			12, 13: begin
				// whitespace run of any of the six separator codes
				for (int i = $urandom_range(1, 3); i > 0; i--)
					add_char($urandom_range(0, 1) ? 8'd32 : 8'($urandom_range(9, 13)));
			end
			14: add_char(8'($urandom));
			default: if ($urandom_range(0, 3) == 0) add_eoi(1'b0); else add_char(" ");
		endcase
		if ($urandom_range(0, 2) == 0)
			add_char($urandom_range(0, 3) == 0 ? 8'($urandom_range(9, 13)) : 8'd32);
	endtask

	// Sender: present one character beat at a time from the pending queue
	always @(posedge clk or negedge arst_n) begin
		logic nv;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
			tx_gap = 0;
		end else begin
			nv = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				scan_char(cur_beat);
				chars_sent++;
				nv = 1'b0;
			end
			if (!nv) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (src_q.size() > 0 &&
						!(src_q[0].drain_first && tok_q.size() > 0)) begin
					cur_beat = src_q[0];
					src_q.delete(0);
					s_axis_tdata <= cur_beat.ch;
					s_axis_tlast <= cur_beat.eoi;
					nv = 1'b1;
					if (chars_sent < chars_total - TAIL_QUIET && $urandom_range(0, 19) == 0)
						tx_gap = $urandom_range(1, 8);
				end
			end
			s_axis_tvalid <= nv;
		end
	end

	// Receiver: check each token beat and pace the ready line
	always @(posedge clk or negedge arst_n) begin
		token_beat_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_gap = 0;
			rx_hold = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (tok_q.size() == 0) begin
					report_mismatch("unexpected beat", m_axis_tdata, 0);
				end else begin
					want = tok_q[0];
					tok_q.delete(0);
					if (m_axis_tdata[5:0] != want.tok.token_kind)
						report_mismatch("token_kind", m_axis_tdata[5:0], want.tok.token_kind);
					if (m_axis_tdata[6] != want.tok.has_token)
						report_mismatch("has_token", m_axis_tdata[6], want.tok.has_token);
					if (m_axis_tdata[14:7] != want.tok.text_length)
						report_mismatch("text_length", m_axis_tdata[14:7], want.tok.text_length);
					if (m_axis_tdata[30:15] != want.tok.start_position)
						report_mismatch("start_position", m_axis_tdata[30:15],
							want.tok.start_position);
					if (m_axis_tdata[32:31] != want.tok.error_code)
						report_mismatch("error_code", m_axis_tdata[32:31], want.tok.error_code);
					if (m_axis_tdata[39:33] != '0)
						report_mismatch("pad bits", m_axis_tdata[39:33], 0);
					if (m_axis_tlast !== want.last)
						report_mismatch("last", m_axis_tlast, want.last);
				end
			end
			// long hold-off once, so the result queue fills and input stalls
			if (!rx_hold_done && chars_sent >= 300) begin
				rx_hold_done = 1'b1;
				rx_hold = 80;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				m_axis_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				if (chars_sent < chars_total - TAIL_QUIET && $urandom_range(0, 15) == 0)
					rx_gap = $urandom_range(1, 8);
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		errors = 0;
		chars_sent = 0;
		quiet_cycles = 0;
		rx_hold_done = 1'b0;
		sc_mode = kwl_pkg::M_IDLE;
		sc_word = '0;
		sc_word_long = 1'b0;
		sc_oper = '0;
		sc_oper_long = 1'b0;
		sc_len = '0;
		sc_start = '0;
		sc_pos = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		arst_n = 1'b0;

		// Directed: keywords, long word, numbers with bad tail, operators,
		// punctuation, strings, comment, unexpected character, end of input
		add_text("IF THEN ENDIF ELSE FOR IN ENDFOR BEGIN END DEFINE true false ");
		add_text("ENDFORx abcdefghij 12.5 7x 3.4.+ - * / % ^ ++ -- == < > <= >= != ");
		add_text("&& || ! = &| +++ ()3,?:; \"ab\"\"\" #note\n@z\t\v\f\r 9");
		add_eoi(1'b1);
		add_text("\"open");
		add_eoi(1'b0);
		add_text("#c");
		add_eoi(1'b0);
		add_text("@");
		add_eoi(1'b0);
		add_eoi(1'b0);
		add_char(8'd0);
		add_char(8'd255);
		add_char(8'd0);
		// Long string saturates the length
		add_char("\"");
		for (int i = 0; i < 300; i++)
			add_char(8'($urandom_range(35, 126)));
		add_char("\"");
		add_text(" x");
		add_eoi(1'b1);

		// Random token streams
		while (src_q.size() < 1340) begin
			add_random_token();
			if ($urandom_range(0, 199) == 0)
				add_eoi(1'b1);
		end
		add_eoi(1'b0);
		chars_total = src_q.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		wait (src_q.size() == 0 && !s_axis_tvalid && tok_q.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && tok_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
`default_nettype wire

>>> filelist.f
rtl/kwl_pkg.sv
rtl/kwl_front.sv
rtl/kwl_back.sv
rtl/keyword_lexer_unit.sv
verif/tb_top.sv
